// ===== sv/rgs_pkg.sv =====
package rgs_pkg;

  // Stream layout
  localparam int HeaderBytes = 16;
  localparam int PixelBytes  = 8;

  localparam logic [3:0] HEADER_LAST = 4'(HeaderBytes - 1);
  localparam logic [2:0] PIXEL_LAST  = 3'(PixelBytes - 1);
  localparam logic [7:0] OPAQUE_BYTE = 8'hFF;

  // Width of 2R + 3G + B for 16-bit channels.
  localparam int SumW = 19;

  // x / 3 == (x * GREY_RECIP) >> GREY_SHIFT for every x below 2**18.
  localparam int            GREY_SHIFT = 19;
  localparam logic [17:0]   GREY_RECIP = 18'd174763;

  // Command queue between front and back; depth must be a power of two.
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCw    = QueueAw + 1;

  typedef enum logic [1:0] {
    STAGE_HEADER = 2'd0,
    STAGE_PIXEL  = 2'd1,
    STAGE_DONE   = 2'd2
  } stage_t;

  // One queued command: a header byte to pass through or a pixel weight sum.
  typedef struct packed {
    logic            is_pixel;
    logic [SumW-1:0] value;
  } cmd_t;

endpackage

// ===== sv/rgba16_to_grey_stream_core.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_ready   in_byte
// output    out_valid / out_ready out_byte, last_of_run
//
// One byte is taken and one byte is given per cycle when neither side stalls.
// A header byte passes through the command queue and the back end's output register
// before it leaves; a pixel's eight result bytes follow its eighth input byte the
// same way and leave one at a time, paced by the single output byte port of the back end.
// A four-entry command queue lets the input keep running while output stalls, until it is full.
// Synchronous reset returns to the header; bytes after the last pixel are
// dropped until reset.
module rgba16_to_grey_stream_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import rgs_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  rgs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rgs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rgs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ===== sv/rgs_front.sv =====
module rgs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          push,
  output rgs_pkg::cmd_t push_cmd
);
  import rgs_pkg::*;

  stage_t      stage;
  stage_t      stage_next;
  logic [3:0]  header_index;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [31:0] column_index;
  logic [31:0] row_index;
  logic [2:0]  pixel_byte_index;
  logic [47:0] colour_bytes;

  logic        need_push;
  logic        take;
  logic [31:0] height_shifted;
  logic [31:0] column_inc;
  logic [31:0] row_inc;
  logic        row_end;
  logic        image_end;
  logic [SumW-1:0] weight_sum;

  assign take           = in_valid && in_ready;
  assign height_shifted = {image_height[23:0], in_byte};
  assign column_inc     = column_index + 32'd1;
  assign row_inc        = row_index + 32'd1;
  assign row_end        = (column_inc == image_width);
  assign image_end      = row_end && (row_inc == image_height);

  // 2R + 3G + B on the gathered channels.
  assign weight_sum = {2'b00, colour_bytes[47:32], 1'b0}
                    + {3'b000, colour_bytes[31:16]}
                    + {2'b00, colour_bytes[31:16], 1'b0}
                    + {3'b000, colour_bytes[15:0]};

  always_comb begin
    stage_next = stage;
    unique case (stage)
      STAGE_HEADER: begin
        if (take && header_index == HEADER_LAST) begin
          // The height is complete only with this byte, so check the shifted value.
          if (image_width == 32'd0 || height_shifted == 32'd0) begin
            stage_next = STAGE_DONE;
          end else begin
            stage_next = STAGE_PIXEL;
          end
        end
      end
      STAGE_PIXEL: begin
        if (take && pixel_byte_index == PIXEL_LAST && image_end) begin
          stage_next = STAGE_DONE;
        end
      end
      default: stage_next = STAGE_DONE;
    endcase
  end

  always_comb begin
    need_push         = 1'b0;
    push_cmd.is_pixel = 1'b0;
    push_cmd.value    = {{(SumW-8){1'b0}}, in_byte};
    unique case (stage)
      STAGE_HEADER: need_push = 1'b1;
      STAGE_PIXEL: begin
        need_push         = (pixel_byte_index == PIXEL_LAST);
        push_cmd.is_pixel = 1'b1;
        push_cmd.value    = weight_sum;
      end
      default: need_push = 1'b0;
    endcase
    in_ready = !(need_push && q_full);
    push     = take && need_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage            <= STAGE_HEADER;
      header_index     <= 4'd0;
      image_width      <= 32'd0;
      image_height     <= 32'd0;
      column_index     <= 32'd0;
      row_index        <= 32'd0;
      pixel_byte_index <= 3'd0;
    end else begin
      stage <= stage_next;
      if (take && stage == STAGE_HEADER) begin
        if (header_index[3:2] == 2'b10) begin
          image_width <= {image_width[23:0], in_byte};
        end else if (header_index[3:2] == 2'b11) begin
          image_height <= height_shifted;
        end
        header_index <= header_index + 4'd1;
      end
      if (take && stage == STAGE_PIXEL) begin
        pixel_byte_index <= pixel_byte_index + 3'd1;
        if (pixel_byte_index == PIXEL_LAST) begin
          if (row_end) begin
            column_index <= 32'd0;
            row_index    <= row_inc;
          end else begin
            column_index <= column_inc;
          end
        end
      end
    end
  end

  // Color gathering: bytes 0..5 of a pixel fill R, G and B, most significant first.
  always_ff @(posedge clk) begin
    if (take && stage == STAGE_PIXEL) begin
      case (pixel_byte_index)
        3'd0:    colour_bytes[47:40] <= in_byte;
        3'd1:    colour_bytes[39:32] <= in_byte;
        3'd2:    colour_bytes[31:24] <= in_byte;
        3'd3:    colour_bytes[23:16] <= in_byte;
        3'd4:    colour_bytes[15:8]  <= in_byte;
        3'd5:    colour_bytes[7:0]   <= in_byte;
        default: colour_bytes        <= colour_bytes;
      endcase
    end
  end

  a_pixel_nonempty: assert property (@(posedge clk) disable iff (rst)
    (stage == STAGE_PIXEL) |-> (image_width != 32'd0 && image_height != 32'd0))
    else $error("pixel stage entered with an empty image");

endmodule

// ===== sv/rgs_queue.sv =====
module rgs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rgs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rgs_pkg::cmd_t head_cmd
);
  import rgs_pkg::*;

  cmd_t               entries [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueCw-1:0] count;

  assign full       = (count == QueueCw'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule

// ===== sv/rgs_back.sv =====
module rgs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  rgs_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last_of_run
);
  import rgs_pkg::*;

  logic        busy;
  logic        is_pixel;
  logic [15:0] data;
  logic [2:0]  byte_index;

  logic [17:0] half_sum;
  logic [35:0] product;
  logic [15:0] grey;
  logic        sent;

  // (2R + 3G + B) / 6 as (sum / 2) / 3, the last by a reciprocal multiply.
  assign half_sum = head_cmd.value[SumW-1:1];
  assign product  = half_sum * GREY_RECIP;
  assign grey     = product[GREY_SHIFT +: 16];

  assign out_valid   = busy;
  assign last_of_run = !is_pixel || (byte_index == PIXEL_LAST);
  assign sent        = out_valid && out_ready;
  assign pop         = head_valid && (!busy || (sent && last_of_run));

  always_comb begin
    if (!is_pixel) begin
      out_byte = data[7:0];
    end else if (byte_index[2:1] == 2'b11) begin
      out_byte = OPAQUE_BYTE;
    end else if (byte_index[0]) begin
      out_byte = data[7:0];
    end else begin
      out_byte = data[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      byte_index <= 3'd0;
    end else if (pop) begin
      busy       <= 1'b1;
      byte_index <= 3'd0;
    end else if (sent) begin
      if (last_of_run) begin
        busy <= 1'b0;
      end else begin
        byte_index <= byte_index + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_pixel <= head_cmd.is_pixel;
      data     <= head_cmd.is_pixel ? grey : {8'h00, head_cmd.value[7:0]};
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (busy && byte_index == 3'd0))
    else $error("loaded command does not start at its first byte");

endmodule

// ===== sim/grey_stream_checker.sv =====
`timescale 1ns / 100ps

module grey_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        last_of_run,
  output int unsigned mismatch_count,
  output int unsigned bytes_due
);
  import rgs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } out_beat_t;

  out_beat_t   due_beats[$];

  stage_t      stage;
  logic [3:0]  hdr_pos;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [31:0] col;
  logic [31:0] row;
  logic [2:0]  pix_pos;
  logic [47:0] rgb;

  function automatic logic [15:0] weighted_grey(input logic [47:0] px);
    int unsigned total;
    total = 2 * int'(px[47:32]) + 3 * int'(px[31:16]) + int'(px[15:0]);
    return 16'(total / 6);
  endfunction

  // Advances the expected stream by one input item and queues what it produces.
  task automatic absorb_byte(input logic [7:0] b);
    logic [15:0] grey;
    case (stage)
      STAGE_HEADER: begin
        if (hdr_pos >= 4'd8 && hdr_pos < 4'd12) img_w = {img_w[23:0], b};
        else if (hdr_pos >= 4'd12) img_h = {img_h[23:0], b};
        due_beats.push_back('{b, 1'b1});
        if (hdr_pos == HEADER_LAST) begin
          hdr_pos = '0;
          col     = '0;
          row     = '0;
          pix_pos = '0;
          stage   = (img_w == 0 || img_h == 0) ? STAGE_DONE : STAGE_PIXEL;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      STAGE_PIXEL: begin
        if (pix_pos < 3'd6) rgb[(5 - int'(pix_pos)) * 8 +: 8] = b;
        if (pix_pos != PIXEL_LAST) begin
          pix_pos = pix_pos + 3'd1;
        end else begin
          pix_pos = '0;
          grey = weighted_grey(rgb);
          repeat (3) begin
            due_beats.push_back('{grey[15:8], 1'b0});
            due_beats.push_back('{grey[7:0], 1'b0});
          end
          due_beats.push_back('{OPAQUE_BYTE, 1'b0});
          due_beats.push_back('{OPAQUE_BYTE, 1'b1});
          col = col + 1;
          if (col == img_w) begin
            col = '0;
            row = row + 1;
            if (row == img_h) stage = STAGE_DONE;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_beat();
    out_beat_t want;
    if (due_beats.size() == 0) begin
      $error("unexpected item: out_byte=%0h last_of_run=%0b", out_byte, last_of_run);
      mismatch_count++;
    end else begin
      want = due_beats.pop_front();
      if (out_byte !== want.data) begin
        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
        mismatch_count++;
      end
      if (last_of_run !== want.is_last) begin
        $error("last_of_run: expected %0b, got %0b", want.is_last, last_of_run);
        mismatch_count++;
      end
    end
  endtask

  // Results are checked before the input of the same edge is absorbed, so an
  // item can never be matched against bytes it has only just caused.
  always @(posedge clk) begin
    if (rst) begin
      stage   = STAGE_HEADER;
      hdr_pos = '0;
      img_w   = '0;
      img_h   = '0;
      col     = '0;
      row     = '0;
      pix_pos = '0;
      rgb     = '0;
      due_beats.delete();
    end else begin
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) absorb_byte(in_byte);
    end
    bytes_due = due_beats.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned QuietLimit = 400;
  localparam int unsigned TailCycles = 24;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last_of_run;

  int unsigned mismatch_count;
  int unsigned bytes_due;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned ready_hold = 0;

  rgba16_to_grey_stream_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  grey_stream_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .mismatch_count (mismatch_count),
    .bytes_due      (bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver alternates ready and stall runs; long ready runs give
  // stretches where the output never backs up.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      if (!out_ready) begin
        out_ready  <= 1'b1;
        ready_hold <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(1, 6);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("** rgba16_to_grey_stream_core: FAILED **");
      $finish;
    end
  end

  // Called just after a rising edge; returns at the edge that takes the item.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [63:0] rgba);
    for (int i = 7; i >= 0; i--) send_byte(rgba[i * 8 +: 8]);
  endtask

  // Channels often sit at the ends of their range.
  function automatic logic [15:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  initial begin
    logic [63:0] magic;
    int unsigned img_w;
    int unsigned img_h;

    magic = "farbfeld";
    img_w = $urandom_range(1, 6);
    img_h = (24 + img_w - 1) / img_w;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 7; i >= 0; i--) send_byte(magic[i * 8 +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(8'(img_w >> (i * 8)));
    for (int i = 3; i >= 0; i--) send_byte(8'(img_h >> (i * 8)));

    // Full-scale white must come back as 0xFFFF without overflow.
    send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
    for (int p = 1; p < img_w * img_h; p++)
      send_pixel({pick_channel(), pick_channel(), pick_channel(), pick_channel()});

    // Bytes past the last pixel must be swallowed without any result.
    repeat ($urandom_range(8, 16)) send_byte(8'($urandom_range(0, 255)));

    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatch_count == 0)
      $display("** rgba16_to_grey_stream_core: PASSED **");
    else
      $display("** rgba16_to_grey_stream_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rgs_pkg.sv
sv/rgs_front.sv
sv/rgs_queue.sv
sv/rgs_back.sv
sv/rgba16_to_grey_stream_core.sv
sim/grey_stream_checker.sv
sim/tb_top.sv
